@@ hdl/csf_pkg.sv @@
// Shared constants, types and edge-mask functions for the CGA span fill engine.
// Used by the stream interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps

package csf_pkg;

    localparam int ROW_BYTES   = 80;
    localparam int ROWS        = 200;
    localparam int BANK_OFFSET = 'h2000;
    localparam int MEM_DEPTH   = 16384;

    localparam int ADDR_W = $clog2(MEM_DEPTH);
    // unwrapped span address: row base plus byte offset, before the modulo
    localparam int SPAN_AW = 16;

    typedef enum logic [1:0] {
        OP_FILL = 2'd0,
        OP_XOR  = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPAN,
        ST_DRAIN,
        ST_READ,
        ST_DONE
    } t_state;

    // pixels left of the first column, kept in the first byte
    function automatic logic [7:0] keep_left(input logic [1:0] sub);
        logic [7:0] m;
        unique case (sub)
            2'd0: m = 8'h00;
            2'd1: m = 8'hc0;
            2'd2: m = 8'hf0;
            2'd3: m = 8'hfc;
        endcase
        return m;
    endfunction

    // pixels right of the last column, kept in the last byte
    function automatic logic [7:0] keep_right(input logic [1:0] sub);
        logic [7:0] m;
        unique case (sub)
            2'd0: m = 8'h3f;
            2'd1: m = 8'h0f;
            2'd2: m = 8'h03;
            2'd3: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

@@ hdl/csf_stream_if.sv @@
// Valid/ready stream interfaces for the span fill engine: request and result words.
// Depends on csf_pkg for the address width.
`timescale 1ns / 1ps

interface csf_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  op;
    logic [8:0]                  span_left;
    logic [8:0]                  span_right;
    logic [7:0]                  row;
    logic [7:0]                  color_pattern;
    logic [csf_pkg::ADDR_W-1:0]  read_address;

    modport source (
        output valid, op, span_left, span_right, row, color_pattern, read_address,
        input  ready
    );
    modport sink (
        input  valid, op, span_left, span_right, row, color_pattern, read_address,
        output ready
    );
endinterface

interface csf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       span_error;

    modport source (output valid, read_data, span_error, input ready);
    modport sink   (input  valid, read_data, span_error, output ready);
endinterface

@@ hdl/csf_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module csf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/cga_span_fill_engine_unit.sv @@
// Top level of the CGA span fill engine: sequencer around the frame RAM.
// Depends on csf_pkg, csf_stream_if and csf_ram.
`timescale 1ns / 1ps
//
//  channel   direction  payload                                             word
//  i_in      sink       op, span_left, span_right, row, color_pattern,      request
//                       read_address
//  o_out     source     read_data, span_error                               result
//
//  A span is done one read a cycle on the RAM read port, the write-back
//  following in the next cycle on the write port, then ST_DRAIN and ST_DONE.
//  A read goes via ST_READ; a rejected, off-screen or no-op word goes to ST_DONE.
//  After reset a clearing pass writes zero to all 16384 bytes, one a cycle, and
//  i_in.ready stays low until the pass is done.
//  A new request is taken while the previous result waits in the output register;
//  the block stalls only when a second result would overwrite one not yet taken.

module cga_span_fill_engine_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    csf_in_if.sink       i_in,
    csf_out_if.source    o_out
);

    localparam logic [8:0] ROWS_L = 9'(csf_pkg::ROWS);

    csf_pkg::t_state r_state, n_state;

    logic [csf_pkg::ADDR_W-1:0]  r_clr, n_clr;
    logic [csf_pkg::SPAN_AW-1:0] r_addr, n_addr;
    logic [csf_pkg::SPAN_AW-1:0] r_first, n_first;
    logic [csf_pkg::SPAN_AW-1:0] r_last, n_last;
    logic [7:0]                  r_lk, n_lk;
    logic [7:0]                  r_rk, n_rk;
    logic [7:0]                  r_color, n_color;
    logic                        r_xor, n_xor;
    logic                        r_is_read, n_is_read;
    logic                        r_err, n_err;
    logic [csf_pkg::ADDR_W-1:0]  r_raddr, n_raddr;

    logic                        r_pend, n_pend;
    logic [csf_pkg::ADDR_W-1:0]  r_pend_addr, n_pend_addr;
    logic [7:0]                  r_pend_mask, n_pend_mask;

    logic                        r_out_valid, n_out_valid;
    logic [7:0]                  r_out_data, n_out_data;
    logic                        r_out_err, n_out_err;

    logic                        ram_we;
    logic [csf_pkg::ADDR_W-1:0]  ram_waddr;
    logic [7:0]                  ram_wdata;
    logic                        ram_re;
    logic [csf_pkg::ADDR_W-1:0]  ram_raddr;
    logic [7:0]                  ram_rdata;

    logic                        accept;
    logic [csf_pkg::SPAN_AW-1:0] row_base;
    logic [7:0]                  span_mask;
    logic [7:0]                  color_masked;

    csf_ram #(
        .WIDTH (8),
        .DEPTH (csf_pkg::MEM_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready       = (r_state == csf_pkg::ST_IDLE);
    assign accept           = i_in.valid && i_in.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.read_data  = r_out_data;
    assign o_out.span_error = r_out_err;

    // even rows in the low bank, odd rows one bank offset up
    assign row_base = csf_pkg::SPAN_AW'(i_in.row[7:1]) * csf_pkg::SPAN_AW'(csf_pkg::ROW_BYTES)
                    + (i_in.row[0] ? csf_pkg::SPAN_AW'(csf_pkg::BANK_OFFSET)
                                   : csf_pkg::SPAN_AW'(0));

    always_comb begin
        span_mask = 8'hff;
        if (r_addr == r_first) begin
            span_mask = span_mask & ~r_lk;
        end
        if (r_addr == r_last) begin
            span_mask = span_mask & ~r_rk;
        end
    end

    assign color_masked = r_color & r_pend_mask;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_addr      = r_addr;
        n_first     = r_first;
        n_last      = r_last;
        n_lk        = r_lk;
        n_rk        = r_rk;
        n_color     = r_color;
        n_xor       = r_xor;
        n_is_read   = r_is_read;
        n_err       = r_err;
        n_raddr     = r_raddr;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_pend_mask = r_pend_mask;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_err   = r_out_err;

        ram_re    = 1'b0;
        ram_raddr = r_addr[csf_pkg::ADDR_W-1:0];
        ram_we    = r_pend;
        ram_waddr = r_pend_addr;
        ram_wdata = r_xor ? (ram_rdata ^ color_masked)
                          : ((ram_rdata & ~r_pend_mask) | color_masked);

        if (o_out.ready && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            csf_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 8'h00;
                n_clr     = r_clr + 1'b1;
                if (r_clr == csf_pkg::ADDR_W'(csf_pkg::MEM_DEPTH - 1)) begin
                    n_state = csf_pkg::ST_IDLE;
                end
            end
            csf_pkg::ST_IDLE: begin
                if (accept) begin
                    n_first   = row_base + csf_pkg::SPAN_AW'(i_in.span_left[8:2]);
                    n_last    = row_base + csf_pkg::SPAN_AW'(i_in.span_right[8:2]);
                    n_addr    = row_base + csf_pkg::SPAN_AW'(i_in.span_left[8:2]);
                    n_lk      = csf_pkg::keep_left(i_in.span_left[1:0]);
                    n_rk      = csf_pkg::keep_right(i_in.span_right[1:0]);
                    n_color   = i_in.color_pattern;
                    n_xor     = (i_in.op == csf_pkg::OP_XOR);
                    n_raddr   = i_in.read_address;
                    n_is_read = 1'b0;
                    n_err     = 1'b0;
                    n_state   = csf_pkg::ST_DONE;
                    unique case (csf_pkg::t_op'(i_in.op))
                        csf_pkg::OP_FILL, csf_pkg::OP_XOR: begin
                            if (i_in.span_left > i_in.span_right) begin
                                n_err = 1'b1;
                            end else if ({1'b0, i_in.row} < ROWS_L) begin
                                n_state = csf_pkg::ST_SPAN;
                            end
                        end
                        csf_pkg::OP_READ: begin
                            n_is_read = 1'b1;
                            n_state   = csf_pkg::ST_READ;
                        end
                        csf_pkg::OP_NOP: begin
                            n_state = csf_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            csf_pkg::ST_SPAN: begin
                // read this byte; its write-back follows next cycle
                ram_re      = 1'b1;
                n_pend      = 1'b1;
                n_pend_addr = r_addr[csf_pkg::ADDR_W-1:0];
                n_pend_mask = span_mask;
                n_addr      = r_addr + 1'b1;
                if (r_addr == r_last) begin
                    n_state = csf_pkg::ST_DRAIN;
                end
            end
            csf_pkg::ST_DRAIN: begin
                n_state = csf_pkg::ST_DONE;
            end
            csf_pkg::ST_READ: begin
                ram_re    = 1'b1;
                ram_raddr = r_raddr;
                n_state   = csf_pkg::ST_DONE;
            end
            csf_pkg::ST_DONE: begin
                // hold until the output register is free; RAM data holds meanwhile
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_is_read ? ram_rdata : 8'h00;
                    n_out_err   = r_err;
                    n_state     = csf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = csf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csf_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_first     <= n_first;
        r_last      <= n_last;
        r_lk        <= n_lk;
        r_rk        <= n_rk;
        r_color     <= n_color;
        r_xor       <= n_xor;
        r_is_read   <= n_is_read;
        r_err       <= n_err;
        r_raddr     <= n_raddr;
        r_pend_addr <= n_pend_addr;
        r_pend_mask <= n_pend_mask;
        r_out_data  <= n_out_data;
        r_out_err   <= n_out_err;
    end

endmodule
